@@ hdl/pidaw_pkg.sv @@
`default_nettype none

package pidaw_pkg;

    // number formats
    localparam int DATA_WIDTH       = 32;
    localparam int FRAC_BITS        = 16;
    localparam int INTEGRATOR_WIDTH = 48;

    localparam int ERR_W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int MUL_A_W = (INTEGRATOR_WIDTH > DATA_WIDTH) ? INTEGRATOR_WIDTH : DATA_WIDTH;
    localparam int MUL_B_W = 32;
    localparam int RES_W   = 64;
    localparam int WIDE_W  = 66;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int MODE_DEG_BIT      = 0;
    localparam int MODE_BACKCALC_BIT = 1;

    // pi/180 in the data format
    localparam longint unsigned DEG2RAD_L =
        (((64'd1 << FRAC_BITS) * 64'd17453293) + 64'd500000000) / 64'd1000000000;
    localparam logic signed [MUL_B_W-1:0] DEG2RAD = MUL_B_W'(DEG2RAD_L);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN         = 3'd0,
        REG_INTEGRAL_GAIN     = 3'd1,
        REG_DERIV_GAIN        = 3'd2,
        REG_BACKCALC_GAIN     = 3'd3,
        REG_SAMPLE_PERIOD     = 3'd4,
        REG_OUTPUT_LIMITS     = 3'd5,
        REG_INTEGRATOR_LIMITS = 3'd6,
        REG_MODE              = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integral_gain;
        logic signed [31:0] deriv_gain_per_period;
        logic signed [31:0] backcalc_gain;
        logic [30:0]        sample_period;
        logic [63:0]        output_limits;
        logic [63:0]        integrator_limits;
        logic [1:0]         mode;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_ISSUE,
        ST_WAIT,
        ST_INTEG,
        ST_CLIP,
        ST_SUM,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        OP_DEG,
        OP_P,
        OP_D,
        OP_IOLD,
        OP_ESP,
        OP_EXC,
        OP_I
    } mul_op_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_PROD,
        MS_ACC,
        MS_RND
    } mul_state_t;

    typedef struct packed {
        logic signed [WIDE_W-1:0] value;
        logic                     hit;
    } clamp_t;

    // saturate to w signed bits
    function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v,
                                                          input int w);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (WIDE_W'(1) <<< (w - 1)) - WIDE_W'(1);
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            sat_wide = hi;
        end else if (v < lo) begin
            sat_wide = lo;
        end else begin
            sat_wide = v;
        end
    endfunction

    // max is tested first, so with crossed limits a value above the max gets the max and any other value the min
    function automatic clamp_t clamp_lim(input logic signed [WIDE_W-1:0] v,
                                         input logic [63:0] lim);
        clamp_t                   r;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        lo = WIDE_W'($signed(lim[31:0]));
        hi = WIDE_W'($signed(lim[63:32]));
        r.value = v;
        r.hit   = 1'b0;
        if (v > hi) begin
            r.value = hi;
            r.hit   = 1'b1;
        end else if (v < lo) begin
            r.value = lo;
            r.hit   = 1'b1;
        end
        clamp_lim = r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/pid_antiwindup_controller.sv @@
`default_nettype none

// PID controller with back-calculation anti-windup; Q16.16 data, Q32.16 integrator.
// Each input transfer carries a process value and a setpoint; each produces exactly
// one result transfer with the clamped drive and a flag that is set when the output
// limits were hit. Gains, period, limits and mode must be written through the cfg
// port only while the block is idle; the block itself does not enforce this. All
// products go through one shared 32x32 multiplier under a small sequencer, so the
// block takes one item at a time; a multiply takes an extra product and accumulate
// pass when the integrator operand needs its upper bits. Degree conversion and
// back-calculation mode each add multiplies to an item. The input side is ready
// again in the cycle after the result is loaded, while that result may still wait
// for the downstream side.
module pid_antiwindup_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // measured [31:0], target [63:32]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // drive [31:0]
    output logic             m_axis_tuser,   // clamped [0]
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import pidaw_pkg::*;

    cfg_regs_t  cfg;
    ctl_state_t state_reg, state_next;
    mul_op_t    op_reg, op_next;

    // shared multiplier
    logic                       mul_start;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic                       mul_done;
    logic signed [RES_W-1:0]    mul_res;
    logic signed [DATA_WIDTH-1:0] mul_res_sat;

    // control state of the loop
    logic signed [INTEGRATOR_WIDTH-1:0] acc_reg;
    logic signed [ERR_W-1:0]            last_err_reg;
    logic                               m_valid_reg;
    logic                               out_load;

    // per-item working registers
    logic signed [31:0]                 meas_reg;
    logic signed [31:0]                 tgt_reg;
    logic signed [ERR_W-1:0]            e_reg;
    logic signed [DATA_WIDTH-1:0]       ediff_reg;
    logic signed [DATA_WIDTH-1:0]       p_reg;
    logic signed [DATA_WIDTH-1:0]       d_reg;
    logic signed [DATA_WIDTH:0]         pd_reg;
    logic signed [DATA_WIDTH-1:0]       u_reg;
    logic signed [DATA_WIDTH-1:0]       excess_reg;
    logic signed [RES_W-1:0]            t1_reg;
    logic signed [RES_W-1:0]            t2_reg;
    logic signed [INTEGRATOR_WIDTH-1:0] acc_tmp_reg;
    logic signed [DATA_WIDTH-1:0]       i_reg;
    logic signed [DATA_WIDTH-1:0]       sum_reg;
    logic signed [31:0]                 m_drive_reg;
    logic                               m_clamped_reg;

    logic   deg_mode;
    logic   bc_mode;
    clamp_t u_clip;
    clamp_t int_clip;
    clamp_t out_clip;
    logic signed [DATA_WIDTH-1:0] excess_val;

    assign deg_mode = cfg.mode[MODE_DEG_BIT];
    assign bc_mode  = cfg.mode[MODE_BACKCALC_BIT];

    // register file, always ready
    assign cfg_ready = 1'b1;

    pidaw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg)
    );

    pidaw_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign mul_res_sat = DATA_WIDTH'(sat_wide(WIDE_W'(mul_res), DATA_WIDTH));

    // clamp of the unlimited output for the back-calculation excess
    assign u_clip     = clamp_lim(WIDE_W'(u_reg), cfg.output_limits);
    assign excess_val = DATA_WIDTH'(sat_wide(u_clip.value - WIDE_W'(u_reg), DATA_WIDTH));
    // integrator limits, back-calculation mode only
    assign int_clip   = clamp_lim(WIDE_W'(acc_tmp_reg), cfg.integrator_limits);
    // final output clamp and flag
    assign out_clip   = clamp_lim(WIDE_W'(sum_reg), cfg.output_limits);

    // operand select for the multiplier
    always_comb begin
        unique case (op_reg) inside
            OP_DEG: begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = DEG2RAD;
            end
            OP_P: begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = cfg.prop_gain;
            end
            OP_D: begin
                mul_a = MUL_A_W'(ediff_reg);
                mul_b = cfg.deriv_gain_per_period;
            end
            OP_IOLD, OP_I: begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = cfg.integral_gain;
            end
            OP_ESP: begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = $signed({1'b0, cfg.sample_period});
            end
            OP_EXC: begin
                mul_a = MUL_A_W'(excess_reg);
                mul_b = cfg.backcalc_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer: error, (degree conversion), P, D, (old I), integrator update, I, sum, output
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_ERR;
            end
            ST_ERR: begin
                state_next = ST_ISSUE;
                op_next    = deg_mode ? OP_DEG : OP_P;
            end
            ST_ISSUE: begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_DEG:  op_next = OP_P;
                        OP_P:    op_next = OP_D;
                        OP_D:    op_next = bc_mode ? OP_IOLD : OP_ESP;
                        OP_IOLD: op_next = OP_ESP;
                        OP_ESP: begin
                            if (bc_mode) begin
                                op_next = OP_EXC;
                            end else begin
                                state_next = ST_INTEG;
                            end
                        end
                        OP_EXC:  state_next = ST_INTEG;
                        OP_I:    state_next = ST_SUM;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INTEG: state_next = ST_CLIP;
            ST_CLIP: begin
                op_next    = OP_I;
                state_next = ST_ISSUE;
            end
            ST_SUM: state_next = ST_OUT;
            ST_OUT: begin
                // the output register frees up in the same cycle it is taken
                if (!m_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_P;
            m_valid_reg  <= 1'b0;
            acc_reg      <= '0;
            last_err_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (out_load) begin
                m_valid_reg  <= 1'b1;
                last_err_reg <= e_reg;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CLIP) begin
                acc_reg <= bc_mode ? INTEGRATOR_WIDTH'(int_clip.value) : acc_tmp_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            meas_reg <= s_axis_tdata[31:0];
            tgt_reg  <= s_axis_tdata[63:32];
        end
        if (state_reg == ST_ERR) begin
            e_reg  <= ERR_W'(sat_wide(WIDE_W'(tgt_reg) - WIDE_W'(meas_reg), ERR_W));
            t2_reg <= '0;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            case (op_reg)
                OP_DEG: e_reg <= ERR_W'(sat_wide(WIDE_W'(mul_res), ERR_W));
                OP_P: begin
                    p_reg     <= mul_res_sat;
                    ediff_reg <= DATA_WIDTH'(sat_wide(WIDE_W'(e_reg) - WIDE_W'(last_err_reg),
                                                      DATA_WIDTH));
                end
                OP_D: begin
                    d_reg  <= mul_res_sat;
                    pd_reg <= (DATA_WIDTH + 1)'(p_reg) + (DATA_WIDTH + 1)'(mul_res_sat);
                end
                OP_IOLD: begin
                    u_reg <= DATA_WIDTH'(sat_wide(WIDE_W'(pd_reg) + WIDE_W'(mul_res_sat),
                                                  DATA_WIDTH));
                end
                OP_ESP: begin
                    t1_reg     <= mul_res;
                    excess_reg <= excess_val;
                end
                OP_EXC: t2_reg <= mul_res;
                OP_I:   i_reg  <= mul_res_sat;
                default: begin
                end
            endcase
        end
        if (state_reg == ST_INTEG) begin
            acc_tmp_reg <= INTEGRATOR_WIDTH'(sat_wide(WIDE_W'(acc_reg) + WIDE_W'(t1_reg)
                                                      + WIDE_W'(t2_reg), INTEGRATOR_WIDTH));
        end
        if (state_reg == ST_SUM) begin
            sum_reg <= DATA_WIDTH'(sat_wide(WIDE_W'(p_reg) + WIDE_W'(i_reg) + WIDE_W'(d_reg),
                                            DATA_WIDTH));
        end
        if (out_load) begin
            m_drive_reg   <= 32'(out_clip.value);
            m_clamped_reg <= out_clip.hit;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_drive_reg;
    assign m_axis_tuser  = m_clamped_reg;

`ifndef SYNTH
    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside of a wait state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a transfer");

    a_unclamped_passes_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_axis_tvalid
                     && (m_clamped_reg || m_drive_reg == 32'($past(sum_reg))))
        else $error("unclamped drive differs from the sum");

    a_integ_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLIP && bc_mode
            && $signed(cfg.integrator_limits[31:0]) <= $signed(cfg.integrator_limits[63:32])
        |=> acc_reg <= $signed($past(cfg.integrator_limits[63:32]))
            && acc_reg >= $signed($past(cfg.integrator_limits[31:0])))
        else $error("integrator outside its limits after back-calculation");
`endif

endmodule

`default_nettype wire

@@ hdl/pidaw_cfg.sv @@
`default_nettype none

module pidaw_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pidaw_pkg::cfg_regs_t                  cfg_regs
);
    import pidaw_pkg::*;

    cfg_regs_t regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.prop_gain             <= '0;
            regs_reg.integral_gain         <= '0;
            regs_reg.deriv_gain_per_period <= '0;
            regs_reg.backcalc_gain         <= '0;
            regs_reg.sample_period         <= 31'd65536;
            regs_reg.output_limits         <= 64'h7FFF_FFFF_8000_0000;
            regs_reg.integrator_limits     <= 64'h7FFF_FFFF_8000_0000;
            regs_reg.mode                  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PROP_GAIN:         regs_reg.prop_gain             <= cfg_data[31:0];
                REG_INTEGRAL_GAIN:     regs_reg.integral_gain         <= cfg_data[31:0];
                REG_DERIV_GAIN:        regs_reg.deriv_gain_per_period <= cfg_data[31:0];
                REG_BACKCALC_GAIN:     regs_reg.backcalc_gain         <= cfg_data[31:0];
                REG_SAMPLE_PERIOD:     regs_reg.sample_period         <= cfg_data[30:0];
                REG_OUTPUT_LIMITS:     regs_reg.output_limits         <= cfg_data;
                REG_INTEGRATOR_LIMITS: regs_reg.integrator_limits     <= cfg_data;
                REG_MODE:              regs_reg.mode                  <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_regs = regs_reg;

endmodule

`default_nettype wire

@@ hdl/pidaw_mul.sv @@
`default_nettype none

module pidaw_mul (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [pidaw_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [pidaw_pkg::MUL_B_W-1:0] op_b,
    output logic                                     done,
    output logic signed [pidaw_pkg::RES_W-1:0]       result
);
    import pidaw_pkg::*;

    localparam int NCHUNK = (MUL_A_W + 31) / 32;
    localparam int SEL_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W  = NCHUNK * 32;
    localparam int ACC_W  = MUL_A_W + 32;

    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] MAG_LIM = ACC_W'(1) << (RES_W - 1);
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    mul_state_t mstate_reg, mstate_next;

    logic [MUL_A_W-1:0]       a_mag_reg;
    logic [MUL_B_W-1:0]       b_mag_reg;
    logic                     neg_reg;
    logic [SEL_W-1:0]         sel_reg;
    logic [63:0]              prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [RES_W-1:0]  result_reg;
    logic                     done_reg;

    logic [PAD_W-1:0]         a_pad;
    logic [31:0]              chunk;
    logic                     more;
    logic [ACC_W-1:0]         acc_add;
    logic [ACC_W-1:0]         mag;
    logic signed [RES_W-1:0]  res_val;

    assign a_pad = PAD_W'(a_mag_reg);
    assign chunk = a_pad[{sel_reg, 5'b0} +: 32];

    // any nonzero chunk above the current one
    always_comb begin
        more = 1'b0;
        for (int k = 0; k < NCHUNK; k++) begin
            if (k > int'(sel_reg) && a_pad[k*32 +: 32] != 32'd0) begin
                more = 1'b1;
            end
        end
    end

    assign acc_add = ACC_W'(prod_reg) << {sel_reg, 5'b0};
    assign mag     = (acc_reg + HALF) >> FRAC_BITS;

    always_comb begin
        if (neg_reg) begin
            res_val = (mag >= MAG_LIM) ? RES_MIN : -$signed(RES_W'(mag));
        end else begin
            res_val = (mag >= MAG_LIM) ? RES_MAX : $signed(RES_W'(mag));
        end
    end

    always_comb begin
        mstate_next = mstate_reg;
        unique case (mstate_reg)
            MS_IDLE: if (start) mstate_next = MS_PROD;
            MS_PROD: mstate_next = MS_ACC;
            MS_ACC:  mstate_next = more ? MS_PROD : MS_RND;
            MS_RND:  mstate_next = MS_IDLE;
            default: mstate_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mstate_reg <= MS_IDLE;
            done_reg   <= 1'b0;
        end else begin
            mstate_reg <= mstate_next;
            done_reg   <= (mstate_reg == MS_RND);
        end
    end

    always_ff @(posedge aclk) begin
        if (mstate_reg == MS_IDLE && start) begin
            a_mag_reg <= op_a[MUL_A_W-1] ? MUL_A_W'(-op_a) : MUL_A_W'(op_a);
            b_mag_reg <= op_b[MUL_B_W-1] ? MUL_B_W'(-op_b) : MUL_B_W'(op_b);
            neg_reg   <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
            sel_reg   <= '0;
            acc_reg   <= '0;
        end
        if (mstate_reg == MS_PROD) begin
            prod_reg <= chunk * b_mag_reg;
        end
        if (mstate_reg == MS_ACC) begin
            acc_reg <= acc_reg + acc_add;
            if (more) begin
                sel_reg <= sel_reg + SEL_W'(1);
            end
        end
        if (mstate_reg == MS_RND) begin
            result_reg <= res_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
